FILE: rtl/core/vector3_normalize_macros.svh
// assertion macros of the checker file
`ifndef VECTOR3_NORMALIZE_MACROS_SVH
`define VECTOR3_NORMALIZE_MACROS_SVH

// antecedent in one cycle implies consequent in the same cycle
`define VN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent in one cycle implies consequent in the next cycle
`define VN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/vn_pkg.sv
// shared widths and constants of the vector normalizer
package vn_pkg;
  localparam int CompW  = 16;
  localparam int LenW   = 24;
  localparam int UnitW  = 16;
  localparam int RadW   = 48;
  localparam int RemW   = 38;
  localparam int QW     = 15;
  localparam int SqrtSt = 24;
  localparam int DivSt  = 15;
  localparam logic [QW-1:0] UnitOne = 15'd16384;
endpackage

FILE: rtl/core/vn_if.sv
// request channels of the vector normalizer
interface vn_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [vn_pkg::CompW-1:0]     comp_x;
  logic signed [vn_pkg::CompW-1:0]     comp_y;
  logic signed [vn_pkg::CompW-1:0]     comp_z;
  modport source (output valid, comp_x, comp_y, comp_z, input ready);
  modport sink   (input valid, comp_x, comp_y, comp_z, output ready);
endinterface

interface vn_out_if;
  logic                                valid;
  logic                                ready;
  logic        [vn_pkg::LenW-1:0]      length;
  logic signed [vn_pkg::UnitW-1:0]     unit_x;
  logic signed [vn_pkg::UnitW-1:0]     unit_y;
  logic signed [vn_pkg::UnitW-1:0]     unit_z;
  logic                                zero_vector;
  modport source (output valid, length, unit_x, unit_y, unit_z, zero_vector, input ready);
  modport sink   (input valid, length, unit_x, unit_y, unit_z, zero_vector, output ready);
endinterface

FILE: rtl/core/vector3_normalize.sv
// pipelined 3d vector normalizer: length and unit vector
// channel  | dir | payload
// in_i     | in  | comp_x, comp_y, comp_z (signed q8.8)
// out_o    | out | length, unit_x, unit_y, unit_z (signed q1.14), zero_vector
// one request per cycle while out_o is not stalled; stages: squares, sum of squares, 24 root stages,
// divider load, 15 divide stages (one quotient bit each), output register
// the whole pipeline holds while a result waits and out_o.ready is low
// reset clears the valid bits only
module vector3_normalize (
  input  logic  clk_i,
  input  logic  rst_ni,
  vn_in_if.sink    in_i,
  vn_out_if.source out_o
);
  import vn_pkg::*;

  logic en;
  assign en = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  // square stage
  logic                       v1_q;
  logic [2:0][CompW-1:0]      mag1_q;
  logic [2:0]                 neg1_q;
  logic [2:0][2*CompW-1:0]    sq1_q;
  logic [2:0][CompW-1:0]      mag_in;
  logic [2:0]                 neg_in;

  always_comb begin
    neg_in = {in_i.comp_z[CompW-1], in_i.comp_y[CompW-1], in_i.comp_x[CompW-1]};
    mag_in[0] = neg_in[0] ? CompW'(-in_i.comp_x) : in_i.comp_x;
    mag_in[1] = neg_in[1] ? CompW'(-in_i.comp_y) : in_i.comp_y;
    mag_in[2] = neg_in[2] ? CompW'(-in_i.comp_z) : in_i.comp_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag1_q <= mag_in;
      neg1_q <= neg_in;
      for (int c = 0; c < 3; c++) begin
        sq1_q[c] <= mag_in[c] * mag_in[c];
      end
    end
  end

  // square root stages
  logic                  sv_q   [SqrtSt+1];
  logic [RadW-1:0]       rv_q   [SqrtSt+1];
  logic [RadW-1:0]       rt_q   [SqrtSt+1];
  logic [2:0][CompW-1:0] smag_q [SqrtSt+1];
  logic [2:0]            sneg_q [SqrtSt+1];
  logic [2*CompW-1:0]    sum_sq;

  assign sum_sq = sq1_q[0] + sq1_q[1] + sq1_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[0] <= 1'b0;
    end else if (en) begin
      sv_q[0] <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rv_q[0]   <= {sum_sq, 16'd0};
      rt_q[0]   <= '0;
      smag_q[0] <= mag1_q;
      sneg_q[0] <= neg1_q;
    end
  end

  for (genvar k = 0; k < SqrtSt; k++) begin : g_sqrt
    localparam logic [RadW:0] Bit = (RadW+1)'(1) << (2*SqrtSt - 2 - 2*k);
    logic [RadW:0] trial;
    logic          ge;
    assign trial = {1'b0, rt_q[k]} + Bit;
    assign ge    = {1'b0, rv_q[k]} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k+1] <= 1'b0;
      end else if (en) begin
        sv_q[k+1] <= sv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rv_q[k+1]   <= ge ? rv_q[k] - trial[RadW-1:0] : rv_q[k];
        rt_q[k+1]   <= ge ? (rt_q[k] >> 1) + Bit[RadW-1:0] : rt_q[k] >> 1;
        smag_q[k+1] <= smag_q[k];
        sneg_q[k+1] <= sneg_q[k];
      end
    end
  end

  // divide stages
  logic                  dv_q   [DivSt+1];
  logic [LenW-1:0]       dlen_q [DivSt+1];
  logic [2:0][RemW-1:0]  drem_q [DivSt+1];
  logic [2:0][QW-1:0]    dq_q   [DivSt+1];
  logic [2:0]            dneg_q [DivSt+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en) begin
      dv_q[0] <= sv_q[SqrtSt];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dlen_q[0] <= rt_q[SqrtSt][LenW-1:0];
      dneg_q[0] <= sneg_q[SqrtSt];
      dq_q[0]   <= '0;
      for (int c = 0; c < 3; c++) begin
        drem_q[0][c] <= {smag_q[SqrtSt][c], 22'd0};
      end
    end
  end

  for (genvar j = 0; j < DivSt; j++) begin : g_div
    logic [RemW:0]  dsr;
    logic [2:0]     ge;
    assign dsr = (RemW+1)'(dlen_q[j]) << (DivSt - 1 - j);
    for (genvar c = 0; c < 3; c++) begin : g_lane
      assign ge[c] = {1'b0, drem_q[j][c]} >= dsr;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j+1] <= 1'b0;
      end else if (en) begin
        dv_q[j+1] <= dv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dlen_q[j+1] <= dlen_q[j];
        dneg_q[j+1] <= dneg_q[j];
        for (int c = 0; c < 3; c++) begin
          drem_q[j+1][c] <= ge[c] ? drem_q[j][c] - dsr[RemW-1:0] : drem_q[j][c];
          dq_q[j+1][c]   <= {dq_q[j][c][QW-2:0], ge[c]};
        end
      end
    end
  end

  // output register
  logic                  ov_q;
  logic [LenW-1:0]       olen_q;
  logic [2:0][UnitW-1:0] ounit_q;
  logic                  ozero_q;
  logic [2:0][UnitW-1:0] unit_d;
  logic                  zero_d;

  always_comb begin
    logic [QW-1:0] qs;
    zero_d = dlen_q[DivSt] == '0;
    for (int c = 0; c < 3; c++) begin
      qs = (dq_q[DivSt][c] > UnitOne) ? UnitOne : dq_q[DivSt][c];
      if (zero_d) begin
        unit_d[c] = '0;
      end else if (dneg_q[DivSt][c]) begin
        unit_d[c] = UnitW'(-{1'b0, qs});
      end else begin
        unit_d[c] = {1'b0, qs};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= dv_q[DivSt];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      olen_q  <= dlen_q[DivSt];
      ounit_q <= unit_d;
      ozero_q <= zero_d;
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.length      = olen_q;
  assign out_o.unit_x      = ounit_q[0];
  assign out_o.unit_y      = ounit_q[1];
  assign out_o.unit_z      = ounit_q[2];
  assign out_o.zero_vector = ozero_q;
endmodule

FILE: rtl/core/vn_checker.sv
// port level checks of the vector normalizer and their bind
`include "vector3_normalize_macros.svh"

module vn_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [23:0] length_i,
  input logic [15:0] unit_x_i,
  input logic [15:0] unit_y_i,
  input logic [15:0] unit_z_i,
  input logic        zero_vector_i
);
  `VN_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(length_i) && $stable(unit_x_i), "result dropped under stall")
  `VN_ASSERT_IMP(a_zero_len, clk_i, rst_ni, out_valid_i, zero_vector_i == (length_i == 24'd0), "zero flag and length disagree")
  `VN_ASSERT_IMP(a_zero_unit, clk_i, rst_ni, out_valid_i && zero_vector_i, unit_x_i == 16'd0 && unit_y_i == 16'd0 && unit_z_i == 16'd0, "zero vector with nonzero unit")
endmodule

bind vector3_normalize vn_checker u_vn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .length_i      (out_o.length),
  .unit_x_i      (out_o.unit_x),
  .unit_y_i      (out_o.unit_y),
  .unit_z_i      (out_o.unit_z),
  .zero_vector_i (out_o.zero_vector)
);

FILE: tb/vector3_normalize_tb.sv
// self-checking testbench of the 3d vector normalizer: directed table, random requests
`timescale 1ns / 1ps

module vector3_normalize_tb;
  import vn_pkg::*;

  typedef struct packed {
    logic signed [CompW-1:0] x;
    logic signed [CompW-1:0] y;
    logic signed [CompW-1:0] z;
  } vec_t;

  typedef struct packed {
    logic [LenW-1:0]          length;
    logic signed [UnitW-1:0]  ux;
    logic signed [UnitW-1:0]  uy;
    logic signed [UnitW-1:0]  uz;
    logic                     zero;
  } norm_t;

  typedef struct packed {
    vec_t  v;
    logic  known;
    norm_t res;
  } row_t;

  localparam int Latency   = 43;
  localparam int Watchdog  = 20000;
  localparam int RandItems = 850;
  localparam int HoldLong  = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  vn_in_if  in_if ();
  vn_out_if out_if ();

  vector3_normalize dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  norm_t pending_q[$];
  int    mismatches = 0;
  int    idle_cycles = 0;
  bit    stim_done = 1'b0;
  bit    quiet = 1'b0;
  bit    hold_rx = 1'b0;

  function automatic logic [LenW-1:0] floor_root(logic [47:0] v);
    logic [47:0] root;
    logic [47:0] bitv;
    root = '0;
    bitv = 48'd1 << 46;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v    = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[LenW-1:0];
  endfunction

  function automatic logic signed [UnitW-1:0] unit_comp(logic signed [CompW-1:0] c,
                                                        logic [LenW-1:0] len);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (c < 0) ? 64'(-int'(c)) : 64'(int'(c));
    q   = (mag << 22) / len;
    if (q > 64'(UnitOne)) q = 64'(UnitOne);
    return (c < 0) ? -UnitW'(q) : UnitW'(q);
  endfunction

  function automatic norm_t normalize(vec_t v);
    norm_t r;
    logic [47:0] s;
    s = 48'(int'(v.x) * int'(v.x)) + 48'(int'(v.y) * int'(v.y))
      + 48'(int'(v.z) * int'(v.z));
    r.length = floor_root(s << 16);
    if (r.length == 0) begin
      r.ux = '0; r.uy = '0; r.uz = '0; r.zero = 1'b1;
    end else begin
      r.ux = unit_comp(v.x, r.length);
      r.uy = unit_comp(v.y, r.length);
      r.uz = unit_comp(v.z, r.length);
      r.zero = 1'b0;
    end
    return r;
  endfunction

  function automatic row_t mk(int x, int y, int z, bit known = 1'b0, norm_t res = '0);
    row_t r;
    r.v.x = CompW'(x); r.v.y = CompW'(y); r.v.z = CompW'(z);
    r.known = known;
    r.res = res;
    return r;
  endfunction

  function automatic norm_t nr(int len, int ux, int uy, int uz, bit zero);
    norm_t r;
    r.length = LenW'(len);
    r.ux = UnitW'(ux); r.uy = UnitW'(uy); r.uz = UnitW'(uz);
    r.zero = zero;
    return r;
  endfunction

  // valid stays high after the request so back-to-back requests need no gap
  task automatic send(vec_t v, bit known, norm_t res);
    in_if.valid  <= 1'b1;
    in_if.comp_x <= v.x;
    in_if.comp_y <= v.y;
    in_if.comp_z <= v.z;
    do @(posedge clk_i); while (!in_if.ready);
    pending_q.push_back(known ? res : normalize(v));
    @(negedge clk_i);
  endtask

  task automatic maybe_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
  endtask

  function automatic vec_t rand_vec();
    vec_t v;
    int m;
    m = $urandom_range(0, 5);
    v.x = CompW'($urandom); v.y = CompW'($urandom); v.z = CompW'($urandom);
    if (m == 0) begin
      v.x = CompW'($signed(4'($urandom)));
      v.y = CompW'($signed(4'($urandom)));
      v.z = CompW'($signed(4'($urandom)));
    end else if (m == 1) begin
      v.y = '0; v.z = '0;
    end
    return v;
  endfunction

  // sender
  initial begin
    row_t rows[$];
    vec_t v;
    in_if.valid = 1'b0;
    in_if.comp_x = '0; in_if.comp_y = '0; in_if.comp_z = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    rows.push_back(mk(0, 0, 0, 1'b1, nr(0, 0, 0, 0, 1'b1)));
    rows.push_back(mk(256, 0, 0, 1'b1, nr(65536, 16384, 0, 0, 1'b0)));
    rows.push_back(mk(0, -256, 0, 1'b1, nr(65536, 0, -16384, 0, 1'b0)));
    rows.push_back(mk(0, 0, 1, 1'b1, nr(256, 0, 0, 16384, 1'b0)));
    rows.push_back(mk(-32768, 0, 0, 1'b1, nr(8388608, -16384, 0, 0, 1'b0)));
    rows.push_back(mk(32767, 0, 0, 1'b1, nr(8388352, 16384, 0, 0, 1'b0)));
    rows.push_back(mk(-32768, -32768, -32768));
    rows.push_back(mk(32767, 32767, 32767));
    rows.push_back(mk(-32768, 32767, -1));
    rows.push_back(mk(1, 1, 1));
    rows.push_back(mk(-1, -1, -1));
    rows.push_back(mk(1, 1, 0));
    rows.push_back(mk(3, 4, 0));
    rows.push_back(mk(-3, 0, 4));
    rows.push_back(mk(1, 2, 2));
    rows.push_back(mk(-21846, 21845, -1));
    rows.push_back(mk(12345, -23456, 31000));
    rows.push_back(mk(16'h5555, 16'haaaa, 16'h7fff));
    foreach (rows[i]) begin
      send(rows[i].v, rows[i].known, rows[i].res);
      maybe_gap();
    end
    for (int i = 0; i < RandItems; i++) begin
      if (i == 300) begin
        in_if.valid <= 1'b0;
        wait (pending_q.size() == 0);
        @(negedge clk_i);
      end
      if (i == RandItems - 150) quiet = 1'b1;
      v = rand_vec();
      send(v, 1'b0, '0);
      if (i < 300 || i >= 320) maybe_gap();
    end
    in_if.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // long receiver hold-off while requests keep coming
  initial begin
    wait (rst_ni);
    repeat (400) @(negedge clk_i);
    hold_rx = 1'b1;
    repeat (HoldLong) @(negedge clk_i);
    hold_rx = 1'b0;
  end

  // receiver
  initial begin
    out_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_rx) begin
        out_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // checker
  always @(posedge clk_i) begin
    norm_t got;
    norm_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.length = out_if.length;
      got.ux = out_if.unit_x; got.uy = out_if.unit_y; got.uz = out_if.unit_z;
      got.zero = out_if.zero_vector;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // watchdog and end of run
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= Watchdog) begin
        $display("FAILURE");
        $finish;
      end else if (stim_done && pending_q.size() == 0) begin
        repeat (2 * Latency) @(posedge clk_i);
        if (mismatches == 0 && pending_q.size() == 0) begin
          $display("SUCCESS");
        end else begin
          $display("FAILURE");
        end
        $finish;
      end
    end
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/vn_pkg.sv
rtl/core/vn_if.sv
rtl/core/vector3_normalize.sv
rtl/core/vn_checker.sv
tb/vector3_normalize_tb.sv
